// ----- hdl/gn2d_pkg.sv -----
// shared types, constants and helpers for the 2d gradient noise sampler
package gn2d_pkg;

   localparam int TableBits = 8;
   localparam int FracBits  = 16;
   localparam int QueueDepth = 4;
   localparam int QueueBits  = 2;

   typedef enum logic {
      OP_SAMPLE = 1'b0,
      OP_WRITE  = 1'b1
   } op_type;

   typedef struct packed {
      logic [TableBits-1:0] cx;
      logic [TableBits-1:0] cy;
      logic [FracBits-1:0]  fx;
      logic [FracBits-1:0]  fy;
   } job_type;

   // round half up of a signed product by FracBits
   function automatic logic signed [47:0] rnd(input logic signed [47:0] p);
      logic signed [47:0] s;
      s = p + 48'sd32768;
      return s >>> FracBits;
   endfunction

   // dot product of the offset vector with one of four diagonal gradients
   function automatic logic signed [18:0] grad(input logic [1:0] h,
                                              input logic signed [18:0] px,
                                              input logic signed [18:0] py);
      logic signed [18:0] r;
      case (h)
         2'd0:    r = px + py;
         2'd1:    r = py - px;
         2'd2:    r = -px - py;
         default: r = px - py;
      endcase
      return r;
   endfunction

endpackage

// ----- hdl/gradient_noise_2d_sample.sv -----
// top level of the 2d gradient noise sampler
//   channel   ports            direction  flow
//   request   start/busy/req_  in         accepted when start and not busy
//   response  rsp_valid/rsp_   out        one-cycle strobe, never held off
//   csr       csr_write/data   in         written at once
// a sample passes front register, queue and back end to its strobe,
// one per cycle sustained; table writes give no response, taken at once.
// busy rises only when the queue between front and back end is full,
// which cannot happen as the back end drains one request every cycle.
// reset is synchronous; the permutation table is undefined until written.
module gradient_noise_2d_sample import gn2d_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic                req_operation,
   input  logic signed [15:0]  req_x_coord,
   input  logic signed [15:0]  req_y_coord,
   input  logic [7:0]          req_table_index,
   input  logic [7:0]          req_table_value,
   input  logic                csr_write,
   input  logic [23:0]         csr_data,
   output logic                rsp_valid,
   output logic signed [17:0]  rsp_noise_value
);

   logic    go, tw, jv, ne, full;
   job_type jb, hd;

   assign go = start & ~busy & (req_operation == OP_SAMPLE);
   assign tw = start & ~busy & (req_operation == OP_WRITE);
   assign busy = full;

   gn2d_front u_front (
      .clock, .reset, .csr_write, .csr_data, .go, .req_x_coord, .req_y_coord,
      .job_valid(jv), .job(jb));

   gn2d_queue u_queue (
      .clock, .reset, .push(jv), .push_data(jb), .pop(ne), .not_empty(ne),
      .head(hd), .full(full));

   gn2d_back u_back (
      .clock, .reset, .tw_en(tw), .tw_index(req_table_index),
      .tw_value(req_table_value), .in_valid(ne), .job(hd),
      .out_valid(rsp_valid), .out_value(rsp_noise_value));

   a_go_reaches_queue: assert property (@(posedge clock) disable iff (reset)
      go |=> jv) else $error("sample lost in front end");
   a_never_full: assert property (@(posedge clock) disable iff (reset)
      !full) else $error("queue filled");
   a_write_no_sample: assert property (@(posedge clock) disable iff (reset)
      tw |-> !go) else $error("write and sample together");

endmodule

// ----- hdl/gn2d_front.sv -----
// front end: coordinate scaling and split into cell index and fraction
module gn2d_front import gn2d_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_write,
   input  logic [23:0]         csr_data,
   input  logic                go,
   input  logic signed [15:0]  req_x_coord,
   input  logic signed [15:0]  req_y_coord,
   output logic                job_valid,
   output job_type             job
);

   logic [23:0]        freq_ff;
   logic signed [40:0] sx_ff, sy_ff, sx_in, sy_in;
   logic               v_ff;

   assign sx_in = req_x_coord * $signed({1'b0, freq_ff});
   assign sy_in = req_y_coord * $signed({1'b0, freq_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         freq_ff <= 24'd65536;
         v_ff    <= 1'b0;
      end else begin
         if (csr_write) freq_ff <= csr_data;
         v_ff <= go;
      end
      sx_ff <= sx_in;
      sy_ff <= sy_in;
   end

   assign job_valid = v_ff;
   assign job.cx = sx_ff[FracBits +: TableBits];
   assign job.cy = sy_ff[FracBits +: TableBits];
   assign job.fx = sx_ff[FracBits-1:0];
   assign job.fy = sy_ff[FracBits-1:0];

endmodule

// ----- hdl/gn2d_queue.sv -----
// short request queue between front and back end
module gn2d_queue import gn2d_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_data,
   input  logic    pop,
   output logic    not_empty,
   output job_type head,
   output logic    full
);

   job_type              mem_ff [QueueDepth];
   logic [QueueBits-1:0] wp_ff, rp_ff;
   logic [QueueBits:0]   cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wp_ff <= wp_ff + 1'b1;
         if (pop)  rp_ff <= rp_ff + 1'b1;
         cnt_ff <= cnt_ff + {{QueueBits{1'b0}}, push} - {{QueueBits{1'b0}}, pop};
      end
      if (push) mem_ff[wp_ff] <= push_data;
   end

   assign not_empty = cnt_ff != '0;
   assign full      = cnt_ff == (QueueBits+1)'(QueueDepth);
   assign head      = mem_ff[rp_ff];

endmodule

// ----- hdl/gn2d_back.sv -----
// back end: corner hashing, fade curves, interpolation and saturation
module gn2d_back import gn2d_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                tw_en,
   input  logic [7:0]          tw_index,
   input  logic [7:0]          tw_value,
   input  logic                in_valid,
   input  job_type             job,
   output logic                out_valid,
   output logic signed [17:0]  out_value
);

   localparam logic signed [47:0] One = 48'sd65536;

   // permutation table copies, each read at two addresses with registered data
   logic [7:0] perm_a_ff [1 << TableBits];
   logic [1:0] perm_b_ff [1 << TableBits];
   logic [1:0] perm_c_ff [1 << TableBits];

   // table writes wait in delay registers so samples already in flight see the old table
   logic            tw1_ff, tw2_ff;
   logic [7:0]      ti1_ff, ti2_ff, tv1_ff, tv2_ff;

   // stage 1: first-level hash
   logic            v1_ff;
   job_type         j1_ff;
   logic [7:0]      a0_ff, a1_ff;
   // stage 2: second-level hash, t^2
   logic            v2_ff;
   logic [FracBits-1:0] fx2_ff, fy2_ff;
   logic [1:0]      h_ff [4];
   logic signed [17:0] u2_ff, w2_ff;
   // stage 3: dots, t^3 and q
   logic            v3_ff;
   logic signed [18:0] d_ff [4];
   logic signed [17:0] u3_ff, w3_ff;
   logic signed [21:0] uq_ff, wq_ff;
   // stage 4: fade
   logic            v4_ff;
   logic signed [18:0] d4_ff [4];
   logic signed [17:0] fu_ff, fv_ff;
   // stage 5: vertical lerps
   logic            v5_ff;
   logic signed [18:0] l_ff, r_ff;
   logic signed [17:0] fu5_ff;
   // stage 6: horizontal lerp and saturate
   logic            v6_ff;
   logic signed [17:0] o_ff;

   logic signed [16:0] tx, ty;
   logic signed [33:0] uu_p, ww_p;
   logic signed [34:0] u3_p, w3_p;
   logic signed [21:0] uq_in, wq_in;
   logic signed [39:0] fu_p, fv_p;
   logic signed [37:0] lp, rp, o_p;
   logic signed [47:0] uu_r, ww_r, u3_r, w3_r, fu_r, fv_r, l_in, r_in, o_in;
   logic signed [17:0] fu_in, fv_in;
   logic [7:0] b0, b1;
   logic signed [18:0] px0, px1, py0, py1;

   assign tx = $signed({1'b0, fx2_ff});
   assign ty = $signed({1'b0, fy2_ff});
   assign b0 = a0_ff + j1_ff.cy;
   assign b1 = a1_ff + j1_ff.cy;
   assign px0 = $signed({3'd0, fx2_ff});
   assign px1 = px0 - 19'sd65536;
   assign py0 = $signed({3'd0, fy2_ff});
   assign py1 = py0 - 19'sd65536;

   assign uu_p  = $signed({1'b0, j1_ff.fx}) * $signed({1'b0, j1_ff.fx});
   assign ww_p  = $signed({1'b0, j1_ff.fy}) * $signed({1'b0, j1_ff.fy});
   assign u3_p  = u2_ff * tx;
   assign w3_p  = w2_ff * ty;
   assign uq_in = 22'sd6 * 22'(u2_ff) - 22'sd15 * 22'(tx) + 22'sd655360;
   assign wq_in = 22'sd6 * 22'(w2_ff) - 22'sd15 * 22'(ty) + 22'sd655360;
   assign fu_p  = u3_ff * uq_ff;
   assign fv_p  = w3_ff * wq_ff;
   assign lp    = fv_ff * (20'(d4_ff[2]) - 20'(d4_ff[0]));
   assign rp    = fv_ff * (20'(d4_ff[3]) - 20'(d4_ff[1]));
   assign o_p   = fu5_ff * (20'(r_ff) - 20'(l_ff));

   always_comb begin
      uu_r = rnd(48'(uu_p));
      ww_r = rnd(48'(ww_p));
      u3_r = rnd(48'(u3_p));
      w3_r = rnd(48'(w3_p));
      fu_r = rnd(48'(fu_p));
      fv_r = rnd(48'(fv_p));
      if (fu_r > One)    fu_in = 18'sd65536;
      else if (fu_r < 0) fu_in = '0;
      else               fu_in = fu_r[17:0];
      if (fv_r > One)    fv_in = 18'sd65536;
      else if (fv_r < 0) fv_in = '0;
      else               fv_in = fv_r[17:0];
      l_in = 48'(d4_ff[0]) + rnd(48'(lp));
      r_in = 48'(d4_ff[1]) + rnd(48'(rp));
      o_in = 48'(l_ff) + rnd(48'(o_p));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0; v2_ff <= 1'b0; v3_ff <= 1'b0;
         v4_ff <= 1'b0; v5_ff <= 1'b0; v6_ff <= 1'b0;
         tw1_ff <= 1'b0; tw2_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid; v2_ff <= v1_ff; v3_ff <= v2_ff;
         v4_ff <= v3_ff; v5_ff <= v4_ff; v6_ff <= v5_ff;
         tw1_ff <= tw_en; tw2_ff <= tw1_ff;
      end
      ti1_ff <= tw_index; tv1_ff <= tw_value;
      ti2_ff <= ti1_ff;   tv2_ff <= tv1_ff;
      if (tw2_ff) begin
         perm_a_ff[ti2_ff] <= tv2_ff;
         perm_b_ff[ti2_ff] <= tv2_ff[1:0];
         perm_c_ff[ti2_ff] <= tv2_ff[1:0];
      end
      j1_ff <= job;
      a0_ff <= perm_a_ff[job.cx];
      a1_ff <= perm_a_ff[job.cx + 8'd1];
      fx2_ff <= j1_ff.fx;
      fy2_ff <= j1_ff.fy;
      h_ff[0] <= perm_b_ff[b0];
      h_ff[1] <= perm_b_ff[b1];
      h_ff[2] <= perm_c_ff[b0 + 8'd1];
      h_ff[3] <= perm_c_ff[b1 + 8'd1];
      u2_ff <= uu_r[17:0];
      w2_ff <= ww_r[17:0];
      // stage 3, corner order 00 10 01 11
      d_ff[0] <= grad(h_ff[0], px0, py0);
      d_ff[1] <= grad(h_ff[1], px1, py0);
      d_ff[2] <= grad(h_ff[2], px0, py1);
      d_ff[3] <= grad(h_ff[3], px1, py1);
      u3_ff <= u3_r[17:0];
      w3_ff <= w3_r[17:0];
      uq_ff <= uq_in;
      wq_ff <= wq_in;
      d4_ff <= d_ff;
      fu_ff <= fu_in;
      fv_ff <= fv_in;
      l_ff  <= l_in[18:0];
      r_ff  <= r_in[18:0];
      fu5_ff <= fu_ff;
      if (o_in > 48'sd131071)       o_ff <= 18'sd131071;
      else if (o_in < -48'sd131072) o_ff <= -18'sd131072;
      else                          o_ff <= o_in[17:0];
   end

   assign out_valid = v6_ff;
   assign out_value = o_ff;

endmodule

// ----- sim/tb.sv -----
// testbench for the 2d gradient noise sampler: queued driver, predictor and response checker
`timescale 1ns / 1ps

module tb;
   import gn2d_pkg::*;

   typedef struct {
      op_type             op;
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic [7:0]         idx;
      logic [7:0]         val;
   } noise_req_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   logic                req_operation = OP_SAMPLE;
   logic signed [15:0]  req_x_coord = '0;
   logic signed [15:0]  req_y_coord = '0;
   logic [7:0]          req_table_index = '0;
   logic [7:0]          req_table_value = '0;
   logic                csr_write = 1'b0;
   logic [23:0]         csr_data = '0;
   logic                rsp_valid;
   logic signed [17:0]  rsp_noise_value;

   noise_req_type       pending_q[$];
   logic signed [17:0]  noise_exp_q[$];
   logic [7:0]          perm_copy[256];
   logic [23:0]         freq_copy = 24'd65536;
   int                  idle_pct = 0;
   bit                  hold = 1'b0;
   int                  errors = 0;

   gradient_noise_2d_sample u_top (.*);

   always #6 clock = ~clock;

   function automatic longint rnd_q16(longint p);
      return (p + 64'sd32768) >>> 16;
   endfunction

   function automatic longint fade_q16(longint t);
      longint t2, t3, q, f;
      t2 = rnd_q16(t * t);
      t3 = rnd_q16(t2 * t);
      q  = 6 * t2 - 15 * t + 10 * 65536;
      f  = rnd_q16(t3 * q);
      if (f > 65536) f = 65536;
      if (f < 0) f = 0;
      return f;
   endfunction

   function automatic longint corner_dot(logic [7:0] cx, logic [7:0] cy, longint fx,
                                        longint fy, logic [7:0] dx, logic [7:0] dy);
      logic [7:0] first, h;
      longint     px, py;
      first = perm_copy[8'(cx + dx)];
      h     = perm_copy[8'(first + cy + dy)];
      px    = fx - (dx != 0 ? 65536 : 0);
      py    = fy - (dy != 0 ? 65536 : 0);
      case (h[1:0])
         2'd0:    return px + py;
         2'd1:    return py - px;
         2'd2:    return -px - py;
         default: return px - py;
      endcase
   endfunction

   function automatic logic signed [17:0] noise_sample(logic signed [15:0] x,
                                                      logic signed [15:0] y);
      logic [63:0] sx, sy;
      longint      fx, fy, d00, d10, d01, d11, u, v, lt, rt, r;
      sx  = longint'(x) * longint'(freq_copy);
      sy  = longint'(y) * longint'(freq_copy);
      fx  = sx[15:0];
      fy  = sy[15:0];
      d00 = corner_dot(sx[23:16], sy[23:16], fx, fy, 0, 0);
      d10 = corner_dot(sx[23:16], sy[23:16], fx, fy, 1, 0);
      d01 = corner_dot(sx[23:16], sy[23:16], fx, fy, 0, 1);
      d11 = corner_dot(sx[23:16], sy[23:16], fx, fy, 1, 1);
      u   = fade_q16(fx);
      v   = fade_q16(fy);
      lt  = d00 + rnd_q16(v * (d01 - d00));
      rt  = d10 + rnd_q16(v * (d11 - d10));
      r   = lt + rnd_q16(u * (rt - lt));
      if (r > 131071) r = 131071;
      if (r < -131072) r = -131072;
      return r[17:0];
   endfunction

   // driver: one request presented at a time, held until taken
   always @(posedge clock) begin
      noise_req_type nxt;
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (csr_write) freq_copy = csr_data;
         if (start && !busy) begin
            if (req_operation == OP_WRITE) perm_copy[req_table_index] = req_table_value;
            else noise_exp_q.push_back(noise_sample(req_x_coord, req_y_coord));
         end
         if (!start || !busy) begin
            if (pending_q.size() > 0 && !hold && $urandom_range(99) >= idle_pct) begin
               nxt = pending_q.pop_front();
               start           <= 1'b1;
               req_operation   <= nxt.op;
               req_x_coord     <= nxt.x;
               req_y_coord     <= nxt.y;
               req_table_index <= nxt.idx;
               req_table_value <= nxt.val;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // monitor: responses cannot be held off, so check every strobe
   always @(posedge clock) begin
      logic signed [17:0] want;
      if (!reset && rsp_valid) begin
         if (noise_exp_q.size() == 0) begin
            $display("%0t: unexpected response, expected none, actual %0d",
                     $time, rsp_noise_value);
            errors++;
         end else begin
            want = noise_exp_q.pop_front();
            if (rsp_noise_value !== want) begin
               $display("%0t: noise_value mismatch, expected %0d, actual %0d",
                        $time, want, rsp_noise_value);
               errors++;
            end
         end
      end
   end

   task automatic push_sample(logic signed [15:0] x, logic signed [15:0] y);
      noise_req_type r;
      r.op = OP_SAMPLE; r.x = x; r.y = y;
      r.idx = 8'($urandom); r.val = 8'($urandom);
      pending_q.push_back(r);
   endtask

   task automatic push_write(logic [7:0] idx, logic [7:0] val);
      noise_req_type r;
      r.op = OP_WRITE; r.x = 16'($urandom); r.y = 16'($urandom);
      r.idx = idx; r.val = val;
      pending_q.push_back(r);
   endtask

   task automatic drain();
      do @(negedge clock);
      while (pending_q.size() != 0 || start || noise_exp_q.size() != 0);
      repeat (12) @(negedge clock);
   endtask

   task automatic set_freq(logic [23:0] f);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_data  <= f;
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   function automatic logic signed [15:0] pick_coord();
      case ($urandom_range(5))
         0:       return 16'sh8000;
         1:       return 16'sh7fff;
         2:       return 16'($urandom_range(31)) - 16'sd16;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic random_phase(int n, int idle);
      idle_pct = idle;
      repeat (n) begin
         if ($urandom_range(9) == 0) push_write(8'($urandom), 8'($urandom));
         else push_sample(pick_coord(), pick_coord());
      end
   endtask

   initial begin
      logic signed [15:0] corner[4];
      corner = '{16'sh8000, 16'sh7fff, 16'sd0, -16'sd1};
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      // fill the whole table before any sample reads it
      for (int i = 0; i < 256; i++) push_write(i[7:0], 8'($urandom));
      foreach (corner[i]) foreach (corner[j]) push_sample(corner[i], corner[j]);
      push_sample(16'sd1, 16'sd2);
      push_write(8'd0, 8'd255);
      push_write(8'd255, 8'd0);
      push_sample(16'sd0, 16'sd0);
      push_sample(16'sd255, -16'sd256);
      drain();

      random_phase(60, 0);
      // pause mid-stream until every outstanding sample has come back
      wait (pending_q.size() == 0);
      hold = 1'b1;
      do @(negedge clock); while (start || noise_exp_q.size() != 0);
      hold = 1'b0;
      random_phase(20, 0);
      drain();

      set_freq(24'd0);
      random_phase(40, 78);
      drain();
      set_freq(24'hffffff);
      random_phase(60, 7);
      drain();
      set_freq(24'h001000);
      random_phase(60, 78);
      drain();
      set_freq(24'h028000);
      random_phase(60, 7);
      drain();
      set_freq(24'($urandom));
      random_phase(60, 0);
      drain();
      set_freq(24'd65536);
      random_phase(40, 78);
      drain();

      if (errors == 0) $display("tb: done, clean");
      else $display("tb: done, errors");
      $finish;
   end

   initial begin
      #5000000;
      $display("tb: done, errors");
      $finish;
   end

endmodule
